// ----- rtl/fwt_pkg.sv -----
package fwt_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned CntW = $clog2(Width);
  typedef logic [Width-1:0] word_t;
  typedef logic [Width:0] wide_t;
  typedef logic [CntW-1:0] cnt_t;
endpackage

// ----- rtl/fermat_witness_test_unit.sv -----
// fermat witness round unit
// input channel: in_valid_i / in_stall_o with candidate_i and base_i
// output channel: out_valid_o / out_stall_i with passes_o, coprime_o, residue_o, invalid_o
// one result item per input item, in order
// a candidate of 2 or an invalid input goes straight to the output state
// otherwise a binary gcd runs first, one shift or subtract per cycle,
// then modular power scans 32 exponent bits; each bit needs one square and
// an optional multiply, each a shift-and-add pass of the shared multiplier
// in_stall_o is high from acceptance until the result item is taken
// a stalled result holds its value until out_stall_i drops
// reset clears the sequencer; no item is in flight after reset
module fermat_witness_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] candidate_i,
  input  logic [31:0] base_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        passes_o,
  output logic        coprime_o,
  output logic [31:0] residue_o,
  output logic        invalid_o
);
  typedef enum logic [2:0] {
    StIdle, StGcd, StSq, StMul, StWait, StOut
  } state_e;

  state_e state_q;
  fwt_pkg::word_t x_q, a_q, e_q, r_q, g1_q, g2_q, mb_q, res_q;
  fwt_pkg::cnt_t bit_q;
  logic cop_q, pass_q, inv_q, was_sq_q;
  logic mm_start, mm_done;
  fwt_pkg::word_t mm_p;

  fwt_modmul u_mm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .done_o (mm_done),
    .a_i    (mb_q),
    .b_i    (r_q),
    .m_i    (x_q),
    .p_o    (mm_p)
  );

  assign mm_start = (state_q == StSq) || (state_q == StMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      x_q <= '0; a_q <= '0; e_q <= '0; r_q <= '0; g1_q <= '0; g2_q <= '0;
      mb_q <= '0; res_q <= '0; bit_q <= '0;
      cop_q <= 1'b0; pass_q <= 1'b0; inv_q <= 1'b0; was_sq_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            x_q <= candidate_i;
            a_q <= base_i;
            e_q <= candidate_i - 32'd1;
            g1_q <= base_i;
            g2_q <= candidate_i;
            r_q <= 32'd1;
            bit_q <= fwt_pkg::cnt_t'(fwt_pkg::Width - 1);
            if (candidate_i == 32'd2) begin
              pass_q <= 1'b1; cop_q <= 1'b1; res_q <= 32'd1; inv_q <= 1'b0;
              state_q <= StOut;
            end else if (candidate_i < 32'd2 || base_i < 32'd2 ||
                         base_i >= candidate_i) begin
              pass_q <= 1'b0; cop_q <= 1'b0; res_q <= '0; inv_q <= 1'b1;
              state_q <= StOut;
            end else begin
              inv_q <= 1'b0;
              state_q <= StGcd;
            end
          end
        end
        StGcd: begin
          // binary gcd, both operands nonzero; a shared factor of two means not coprime
          if (!g1_q[0] && !g2_q[0]) begin
            cop_q <= 1'b0;
            mb_q <= r_q;
            state_q <= StSq;
          end else if (!g1_q[0]) begin
            g1_q <= g1_q >> 1;
          end else if (!g2_q[0]) begin
            g2_q <= g2_q >> 1;
          end else if (g1_q == g2_q) begin
            cop_q <= (g1_q == 32'd1);
            mb_q <= r_q;
            state_q <= StSq;
          end else if (g1_q > g2_q) begin
            g1_q <= g1_q - g2_q;
          end else begin
            g2_q <= g2_q - g1_q;
          end
        end
        StSq: begin
          was_sq_q <= 1'b1;
          state_q <= StWait;
        end
        StMul: begin
          was_sq_q <= 1'b0;
          state_q <= StWait;
        end
        StWait: begin
          if (mm_done) begin
            r_q <= mm_p;
            if (was_sq_q && e_q[bit_q]) begin
              mb_q <= a_q;
              state_q <= StMul;
            end else if (bit_q == '0) begin
              res_q <= mm_p;
              pass_q <= cop_q && (mm_p == 32'd1);
              state_q <= StOut;
            end else begin
              bit_q <= bit_q - 1'b1;
              mb_q <= mm_p;
              state_q <= StSq;
            end
          end
        end
        StOut: begin
          if (!out_stall_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign passes_o    = pass_q;
  assign coprime_o   = cop_q;
  assign residue_o   = res_q;
  assign invalid_o   = inv_q;
endmodule

// ----- rtl/fwt_modmul.sv -----
module fwt_modmul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            done_o,
  input  fwt_pkg::word_t  a_i,
  input  fwt_pkg::word_t  b_i,
  input  fwt_pkg::word_t  m_i,
  output fwt_pkg::word_t  p_o
);
  fwt_pkg::word_t acc_q, acc_d, b_q;
  fwt_pkg::cnt_t  cnt_q;
  logic busy_q, done_q;
  fwt_pkg::wide_t dbl, dblr, sum;
  fwt_pkg::word_t accs;

  // one shift-and-add step per cycle, msb of b first
  always_comb begin
    dbl  = {acc_q, 1'b0};
    dblr = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    accs = dblr[fwt_pkg::Width-1:0];
    sum  = {1'b0, accs} + {1'b0, a_i};
    if (b_q[fwt_pkg::Width-1]) begin
      acc_d = (sum >= {1'b0, m_i}) ? fwt_pkg::word_t'(sum - {1'b0, m_i}) :
                                     sum[fwt_pkg::Width-1:0];
    end else begin
      acc_d = accs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        acc_q  <= '0;
        b_q    <= b_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        b_q   <= {b_q[fwt_pkg::Width-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == fwt_pkg::cnt_t'(fwt_pkg::Width - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ----- rtl/fwt_checker.sv -----
module fwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        passes_o,
  input logic        coprime_o,
  input logic [31:0] residue_o,
  input logic        invalid_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(residue_o))
    else $error("result dropped while stalled");
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> !passes_o && !coprime_o && residue_o == 32'd0)
    else $error("invalid result with nonzero fields");
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && passes_o |-> coprime_o && residue_o == 32'd1)
    else $error("pass without unit residue");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("no stall after accepted item");
endmodule

bind fermat_witness_test_unit fwt_checker u_fwt_checker (.*);
